### rtl/rounded_euclidean_node_distance_macros.svh
// Assertion macros shared by the node distance RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef ROUNDED_EUCLIDEAN_NODE_DISTANCE_MACROS_SVH
`define ROUNDED_EUCLIDEAN_NODE_DISTANCE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define REND_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled during reset
`define REND_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define REND_ASSERT_IMP(label, ante, cons, msg)
`define REND_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

### rtl/rend_pkg.sv
// Types and constants for the rounded Euclidean node distance block.
// Used by rend_ctrl, rend_dp and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rend_pkg;

  localparam int NODE_W  = 10;
  localparam int FIELD_W = 32;
  localparam int DIST_W  = 25;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic MODE_EUC_2D = 1'b0;
  localparam logic MODE_EUC_3D = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic  load_wr;
    logic  rd_a;
    logic  rd_b;
    logic  cap_a;
    logic  cap_diff;
    logic  mul_en;
    axis_t mul_axis;
    logic  mul_hi;
    logic  acc_en;
    logic  sq_start;
    logic  sq_step;
    logic  out_load;
  } rend_cmd_t;

  typedef struct packed {
    logic sq_last;
  } rend_sts_t;

endpackage

`default_nettype wire

### rtl/rend_dp.sv
// Datapath: coordinate memory, difference and square unit, accumulator,
// bit-serial square root and the result register. Uses rend_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "rounded_euclidean_node_distance_macros.svh"

module rend_dp #(
  parameter int MAX_NODES  = 1024,
  parameter int COORD_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  rend_pkg::rend_cmd_t          cmd,
  output rend_pkg::rend_sts_t          sts,
  input  wire [rend_pkg::NODE_W-1:0]   in_node_a,
  input  wire [rend_pkg::NODE_W-1:0]   in_node_b,
  input  wire [rend_pkg::FIELD_W-1:0]  in_coord_x,
  input  wire [rend_pkg::FIELD_W-1:0]  in_coord_y,
  input  wire [rend_pkg::FIELD_W-1:0]  in_coord_z,
  output logic [rend_pkg::DIST_W-1:0]  out_rounded_distance
);
  import rend_pkg::*;

  localparam int AW       = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CB       = COORD_BITS;
  localparam int EW       = 3 * CB;
  localparam int DW       = CB + 1;
  localparam int LOW_W    = DW / 2;
  localparam int HI_W     = DW - LOW_W;
  localparam int PW       = DW + HI_W;
  localparam int QW       = 2 * DW + 2;
  localparam int RTW      = QW / 2;
  localparam int REMW     = RTW + 3;
  localparam int SQ_STEPS = RTW;
  localparam int CNTW     = $clog2(SQ_STEPS);

  logic [EW-1:0]     mem_r [MAX_NODES];
  logic [EW-1:0]     rd_data_r;
  logic              rd_ok_r;
  logic [AW-1:0]     node_b_r;
  logic              b_ok_r;
  logic [EW-1:0]     a_r;
  logic [DW-1:0]     d_r [3];
  logic [PW-1:0]     prod_r;
  logic              prod_hi_r;
  logic [QW-1:0]     acc_r;
  logic [QW-1:0]     rad_r;
  logic [REMW-1:0]   rem_r;
  logic [RTW-1:0]    root_r;
  logic [CNTW-1:0]   cnt_r;
  logic [DIST_W-1:0] dist_r;

  logic              a_ok;
  logic              b_ok;
  logic [AW-1:0]     addr_a;
  logic [EW-1:0]     b_val;
  logic [DW-1:0]     diff [3];
  logic [DW-1:0]     mag  [3];
  logic [DW-1:0]     d_sel;
  logic [HI_W-1:0]   m_part;
  logic [PW-1:0]     prod_c;
  logic [QW-1:0]     addend;
  logic [REMW-1:0]   rem_sh;
  logic [REMW-1:0]   trial;
  logic              ge;
  logic [RTW-7:0]    m_inc;

  assign a_ok   = 32'(in_node_a) < MAX_NODES;
  assign b_ok   = 32'(in_node_b) < MAX_NODES;
  assign addr_a = AW'(in_node_a);

  // coordinate memory, entries {z, y, x}; loads beyond the table are dropped
  always_ff @(posedge clk) begin
    if (cmd.load_wr && a_ok) begin
      mem_r[addr_a] <= {in_coord_z[CB-1:0], in_coord_y[CB-1:0], in_coord_x[CB-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_a) begin
      rd_data_r <= mem_r[addr_a];
      rd_ok_r   <= a_ok;
      node_b_r  <= AW'(in_node_b);
      b_ok_r    <= b_ok;
    end else if (cmd.rd_b) begin
      rd_data_r <= mem_r[node_b_r];
      rd_ok_r   <= b_ok_r;
    end
  end

  // a node outside the table sits at the origin
  assign b_val = rd_ok_r ? rd_data_r : '0;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = {a_r[k*CB+CB-1], a_r[k*CB +: CB]} - {b_val[k*CB+CB-1], b_val[k*CB +: CB]};
      mag[k]  = diff[k][DW-1] ? -diff[k] : diff[k];
    end
  end

  always_comb begin
    unique case (cmd.mul_axis)
      AXIS_X:  d_sel = d_r[0];
      AXIS_Y:  d_sel = d_r[1];
      AXIS_Z:  d_sel = d_r[2];
      default: d_sel = '0;
    endcase
  end

  // d*d as d*d_low plus (d*d_high) << LOW_W, one partial product a cycle
  assign m_part = cmd.mul_hi ? d_sel[DW-1:LOW_W] : HI_W'(d_sel[LOW_W-1:0]);
  assign prod_c = d_sel * m_part;
  assign addend = prod_hi_r ? (QW'(prod_r) << LOW_W) : QW'(prod_r);

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      a_r <= b_val;
    end
    if (cmd.cap_diff) begin
      for (int k = 0; k < 3; k++) begin
        d_r[k] <= mag[k];
      end
    end
    if (cmd.mul_en) begin
      prod_r    <= prod_c;
      prod_hi_r <= cmd.mul_hi;
    end
    if (cmd.cap_diff) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + addend;
    end
  end

  // restoring square root, one result bit a cycle
  assign rem_sh = {rem_r[REMW-3:0], rad_r[QW-1:QW-2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (cmd.sq_start) begin
      rad_r  <= acc_r;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CNTW'(SQ_STEPS - 1);
    end else if (cmd.sq_step) begin
      rad_r  <= {rad_r[QW-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[RTW-2:0], ge};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign sts.sq_last = (cnt_r == '0);

  // root has 8 fraction bits: halve to one fraction bit, add one half, drop it
  assign m_inc = {1'b0, root_r[RTW-1:7]} + {{(RTW-7){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      dist_r <= DIST_W'(m_inc[RTW-7:1]);
    end
  end

  assign out_rounded_distance = dist_r;

  `REND_ASSERT_NXT(a_sqrt_stops, cmd.sq_step && sts.sq_last, !cmd.sq_step,
    "square root stepped past its last bit")
  `REND_ASSERT_IMP(a_acc_after_mul, cmd.acc_en, $past(cmd.mul_en),
    "accumulate without a fresh partial product")

endmodule

`default_nettype wire

### rtl/rend_ctrl.sv
// Controller: sequences a query through read, square and root steps,
// holds the mode register and the result valid flag. Uses rend_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "rounded_euclidean_node_distance_macros.svh"

module rend_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  in_action,
  output logic                 out_valid,
  input  wire                  out_stall,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire                  cfg_use_third_axis,
  output rend_pkg::rend_cmd_t  cmd,
  input  rend_pkg::rend_sts_t  sts
);
  import rend_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_B,
    ST_DIFF,
    ST_MUL,
    ST_DRAIN,
    ST_SQ_INIT,
    ST_SQRT,
    ST_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] mcnt_r, mcnt_nxt;
  logic       use3_r, use3_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;
  logic [2:0] mcnt_last;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  // two partial products per axis
  assign mcnt_last = (use3_r == MODE_EUC_3D) ? 3'd5 : 3'd3;

  always_comb begin
    state_nxt     = state_r;
    mcnt_nxt      = mcnt_r;
    use3_nxt      = use3_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.mul_axis  = axis_t'(mcnt_r[2:1]);
    cmd.mul_hi    = mcnt_r[0];

    if (cfg_valid && cfg_ready) begin
      use3_nxt = cfg_use_third_axis;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ACT_QUERY) begin
            cmd.rd_a  = 1'b1;
            state_nxt = ST_RD_B;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_RD_B: begin
        cmd.cap_a = 1'b1;
        cmd.rd_b  = 1'b1;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.cap_diff = 1'b1;
        mcnt_nxt     = '0;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.acc_en = (mcnt_r != '0);
        mcnt_nxt   = mcnt_r + 3'd1;
        if (mcnt_r == mcnt_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.acc_en = 1'b1;
        state_nxt  = ST_SQ_INIT;
      end
      ST_SQ_INIT: begin
        cmd.sq_start = 1'b1;
        state_nxt    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sq_step = 1'b1;
        if (sts.sq_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mcnt_r      <= '0;
      use3_r      <= MODE_EUC_2D;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mcnt_r      <= mcnt_nxt;
      use3_r      <= use3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `REND_ASSERT_IMP(a_out_from_fin, $rose(out_valid_r), $past(state_r == ST_FIN),
    "result raised outside the finish step")
  `REND_ASSERT_NXT(a_query_starts, accept && (in_action == ACT_QUERY),
    state_r == ST_RD_B, "accepted query did not start its reads")

endmodule

`default_nettype wire

### rtl/rounded_euclidean_node_distance.sv
// Top level of the rounded Euclidean node distance block.
// Instantiates rend_ctrl and rend_dp; uses rend_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Holds up to MAX_NODES node coordinates (signed fixed point, 8 fraction
// bits) and answers distance queries rounded to the nearest integer, halves
// up, in planar or 3D mode as set by cfg_use_third_axis. A load item gives
// no result. The square-root unit resolves one root bit a cycle; the two
// table reads share one memory port and the squares are built from two
// partial products per axis. One query is in flight at a time; a new item
// is taken while a finished result waits in the output register. A node
// index at or beyond MAX_NODES is treated as the origin on a query and
// ignored on a load. Reading a node never loaded gives an undefined result.
// The table needs no clearing after reset.
module rounded_euclidean_node_distance #(
  parameter int MAX_NODES  = 1024,
  parameter int COORD_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          in_action,
  input  wire [rend_pkg::NODE_W-1:0]   in_node_a,
  input  wire [rend_pkg::NODE_W-1:0]   in_node_b,
  input  wire [rend_pkg::FIELD_W-1:0]  in_coord_x,
  input  wire [rend_pkg::FIELD_W-1:0]  in_coord_y,
  input  wire [rend_pkg::FIELD_W-1:0]  in_coord_z,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [rend_pkg::DIST_W-1:0]  out_rounded_distance,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire                          cfg_use_third_axis
);
  import rend_pkg::*;

  rend_cmd_t cmd;
  rend_sts_t sts;

  rend_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_use_third_axis (cfg_use_third_axis),
    .cmd                (cmd),
    .sts                (sts)
  );

  rend_dp #(
    .MAX_NODES  (MAX_NODES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_node_a            (in_node_a),
    .in_node_b            (in_node_b),
    .in_coord_x           (in_coord_x),
    .in_coord_y           (in_coord_y),
    .in_coord_z           (in_coord_z),
    .out_rounded_distance (out_rounded_distance)
  );

endmodule

`default_nettype wire
